@@ sv/bba_pkg.sv @@
// Package with sizes, request codes and sequencer states of the bitmap block allocator.
package bba_pkg;

    // Managed area geometry
    localparam int NUM_BLOCKS   = 1024;
    localparam int BLOCK_BYTES  = 64;
    localparam int HEADER_BYTES = 8;

    // Occupancy map is kept as rows of ROW_BITS blocks
    localparam int ROW_BITS  = 32;
    localparam int ROWS      = NUM_BLOCKS / ROW_BITS;
    localparam int ROW_W     = $clog2(ROW_BITS);
    localparam int ROWA_W    = $clog2(ROWS);

    // Derived widths
    localparam int BLK_W     = $clog2(NUM_BLOCKS);
    localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
    localparam int OFS_SHIFT = $clog2(BLOCK_BYTES);

    // Field widths of the stream words
    localparam int REQ_W     = 2;
    localparam int SIZE_W    = 17;
    localparam int OFFS_W    = 17;
    localparam int ADDR_W    = 16;
    localparam int SUM_W     = SIZE_W + 1;
    localparam int IN_DATA_W  = ((SIZE_W + OFFS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((1 + ADDR_W + 1 + CNT_W + CNT_W + 7) / 8) * 8;

    // Request codes carried in tuser
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CHECK = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN_RD,
        ST_SCAN_BIT,
        ST_MARK_RD,
        ST_MARK_LD,
        ST_MARK_BIT,
        ST_MARK_WR,
        ST_FREE_RD,
        ST_FREE_CHK,
        ST_CHK_RD,
        ST_CHK_BIT,
        ST_DONE
    } state_t;

endpackage

@@ sv/bitmap_block_allocator.sv @@
// Top level of the first-fit bitmap block allocator with a bit-serial scan sequencer.
// Check reads the occupancy bit of the header block. Free clears the recorded run block
// by block, writing back each touched 32-block row. Allocate scans block by block with a
// row read per row, then marks the found run the same way. One request at a time; the
// single-bit scan/mark step over the occupancy rows sets how long each request takes.
// Reset and a block count write clear the map through per-row valid bits.
module bitmap_block_allocator (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration: number of managed blocks
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bba_pkg::CNT_W-1:0]           cfg_data,
    // Request stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata from bit 0: size_bytes[16:0], addr_offset[33:17], zero pad
    input  logic [bba_pkg::IN_DATA_W-1:0]       s_tdata,
    // s_tuser: req_type[1:0]
    input  logic [bba_pkg::REQ_W-1:0]           s_tuser,
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata from bit 0: ok[0], result_addr[16:1], is_allocated[17],
    // busy_count[28:18], free_blocks[39:29]
    output logic [bba_pkg::OUT_DATA_W-1:0]      m_tdata
);

    localparam int CNT_W  = bba_pkg::CNT_W;
    localparam int BLK_W  = bba_pkg::BLK_W;
    localparam int ROW_W  = bba_pkg::ROW_W;
    localparam int ROWA_W = bba_pkg::ROWA_W;
    localparam int ROWS   = bba_pkg::ROWS;
    localparam int SUM_W  = bba_pkg::SUM_W;
    localparam int OFS    = bba_pkg::OFS_SHIFT;

    // Control registers
    bba_pkg::state_t                 state_reg, state_next;
    logic [CNT_W-1:0]                total_reg, total_next;
    logic [CNT_W-1:0]                used_reg, used_next;
    logic [ROWS-1:0]                 row_vld_reg, row_vld_next;
    logic                            rvld_q_reg, rvld_q_next;
    logic                            m_tvalid_reg, m_tvalid_next;

    // Payload registers
    logic [bba_pkg::REQ_W-1:0]       req_reg, req_next;
    logic [bba_pkg::SIZE_W-1:0]      size_reg, size_next;
    logic [bba_pkg::OFFS_W-1:0]      off_reg, off_next;
    logic [CNT_W-1:0]                needed_reg, needed_next;
    logic [CNT_W-1:0]                run_reg, run_next;
    logic [CNT_W-1:0]                len_reg, len_next;
    logic [BLK_W-1:0]                k_reg, k_next;
    logic [BLK_W-1:0]                first_reg, first_next;
    logic [BLK_W-1:0]                last_reg, last_next;
    logic [ROWA_W-1:0]               wrow_reg, wrow_next;
    logic [bba_pkg::ROW_BITS-1:0]    row_buf_reg, row_buf_next;
    logic                            set_reg, set_next;
    logic                            done_reg, done_next;
    logic                            ok_reg, ok_next;
    logic [bba_pkg::ADDR_W-1:0]      addr_reg, addr_next;
    logic                            alloc_reg, alloc_next;
    logic [bba_pkg::OUT_DATA_W-1:0]  m_tdata_reg, m_tdata_next;

    // Memory ports
    logic                            occ_wr_en, occ_rd_en;
    logic [ROWA_W-1:0]               occ_wr_addr, occ_rd_addr;
    logic [bba_pkg::ROW_BITS-1:0]    occ_wr_data, occ_rd_data, occ_word;
    logic                            rl_wr_en, rl_rd_en;
    logic [BLK_W-1:0]                rl_wr_addr, rl_rd_addr;
    logic [CNT_W-1:0]                rl_wr_data, rl_rd_data;

    // Occupancy rows and run-length store
    bba_ram #(.WIDTH(bba_pkg::ROW_BITS), .DEPTH(ROWS)) u_occ_ram (
        .clk     (clk),
        .wr_en   (occ_wr_en),
        .wr_addr (occ_wr_addr),
        .wr_data (occ_wr_data),
        .rd_en   (occ_rd_en),
        .rd_addr (occ_rd_addr),
        .rd_data (occ_rd_data)
    );

    bba_ram #(.WIDTH(CNT_W), .DEPTH(bba_pkg::NUM_BLOCKS)) u_rl_ram (
        .clk     (clk),
        .wr_en   (rl_wr_en),
        .wr_addr (rl_wr_addr),
        .wr_data (rl_wr_data),
        .rd_en   (rl_rd_en),
        .rd_addr (rl_rd_addr),
        .rd_data (rl_rd_data)
    );

    // A row never written since the last clear reads as all free
    assign occ_word = rvld_q_reg ? occ_rd_data : '0;

    assign s_tready  = (state_reg == bba_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == bba_pkg::ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Next state and datapath
    always_comb
    begin
        logic [SUM_W-1:0]             size_w;
        logic [SUM_W-1:0]             off_w;
        logic [SUM_W-1:0]             cap_w;
        logic [SUM_W-1:0]             need_w;
        logic [bba_pkg::OFFS_W-1:0]   hdr;
        logic [BLK_W-1:0]             hdr_blk;
        logic [CNT_W-1:0]             run_step;
        logic [BLK_W-1:0]             start_blk;
        logic [CNT_W:0]               end_sum;
        logic [CNT_W-1:0]             cfg_val;
        logic                         bit_val;

        state_next    = state_reg;
        total_next    = total_reg;
        used_next     = used_reg;
        row_vld_next  = row_vld_reg;
        rvld_q_next   = rvld_q_reg;
        m_tvalid_next = m_tvalid_reg;
        req_next      = req_reg;
        size_next     = size_reg;
        off_next      = off_reg;
        needed_next   = needed_reg;
        run_next      = run_reg;
        len_next      = len_reg;
        k_next        = k_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        wrow_next     = wrow_reg;
        row_buf_next  = row_buf_reg;
        set_next      = set_reg;
        done_next     = done_reg;
        ok_next       = ok_reg;
        addr_next     = addr_reg;
        alloc_next    = alloc_reg;
        m_tdata_next  = m_tdata_reg;

        occ_wr_en   = 1'b0;
        occ_wr_addr = wrow_reg;
        occ_wr_data = row_buf_reg;
        occ_rd_en   = 1'b0;
        occ_rd_addr = k_reg[BLK_W-1:ROW_W];
        rl_wr_en    = 1'b0;
        rl_wr_addr  = k_reg;
        rl_wr_data  = '0;
        rl_rd_en    = 1'b0;
        rl_rd_addr  = first_reg;

        // Shared request arithmetic
        size_w   = SUM_W'(size_reg);
        off_w    = SUM_W'(off_reg);
        cap_w    = SUM_W'({total_reg, {OFS{1'b0}}});
        need_w   = (size_w + SUM_W'(bba_pkg::HEADER_BYTES + bba_pkg::BLOCK_BYTES - 1)) >> OFS;
        hdr      = off_reg - bba_pkg::OFFS_W'(bba_pkg::HEADER_BYTES);
        hdr_blk  = BLK_W'(hdr >> OFS);
        bit_val  = occ_word[k_reg[ROW_W-1:0]];
        run_step = bit_val ? '0 : run_reg + CNT_W'(1);
        start_blk = BLK_W'(CNT_W'(k_reg) + CNT_W'(1) - run_step);
        end_sum  = (CNT_W+1)'(first_reg) + (CNT_W+1)'(rl_rd_data);

        // Clamp a written block count into the supported range
        cfg_val = cfg_data;
        if (cfg_val == '0)
        begin
            cfg_val = CNT_W'(1);
        end
        else if (cfg_val > CNT_W'(bba_pkg::NUM_BLOCKS))
        begin
            cfg_val = CNT_W'(bba_pkg::NUM_BLOCKS);
        end

        // Output register drains independently of the sequencer
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            bba_pkg::ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    total_next   = cfg_val;
                    used_next    = '0;
                    row_vld_next = '0;
                end
                if (s_tvalid)
                begin
                    req_next   = s_tuser;
                    size_next  = s_tdata[bba_pkg::SIZE_W-1:0];
                    off_next   = s_tdata[bba_pkg::SIZE_W +: bba_pkg::OFFS_W];
                    ok_next    = 1'b0;
                    addr_next  = '0;
                    alloc_next = 1'b0;
                    state_next = bba_pkg::ST_PREP;
                end
            end

            // Bounds checks and setup for the chosen request
            bba_pkg::ST_PREP:
            begin
                state_next = bba_pkg::ST_DONE;
                case (req_reg)
                    bba_pkg::REQ_ALLOC:
                    begin
                        if (size_reg != '0 && size_w <= cap_w
                            && need_w <= SUM_W'(total_reg))
                        begin
                            needed_next = CNT_W'(need_w);
                            k_next      = '0;
                            run_next    = '0;
                            state_next  = bba_pkg::ST_SCAN_RD;
                        end
                    end
                    bba_pkg::REQ_FREE:
                    begin
                        if (off_reg >= bba_pkg::OFFS_W'(bba_pkg::HEADER_BYTES)
                            && SUM_W'(hdr) < cap_w)
                        begin
                            first_next = hdr_blk;
                            state_next = bba_pkg::ST_FREE_RD;
                        end
                    end
                    bba_pkg::REQ_CHECK:
                    begin
                        if (off_reg >= bba_pkg::OFFS_W'(bba_pkg::HEADER_BYTES)
                            && off_w < cap_w)
                        begin
                            k_next     = hdr_blk;
                            state_next = bba_pkg::ST_CHK_RD;
                        end
                    end
                    default:
                    begin
                        state_next = bba_pkg::ST_DONE;
                    end
                endcase
            end

            // First-fit scan, one block per cycle, with a row read step between rows
            bba_pkg::ST_SCAN_RD:
            begin
                occ_rd_en   = 1'b1;
                rvld_q_next = row_vld_reg[k_reg[BLK_W-1:ROW_W]];
                state_next  = bba_pkg::ST_SCAN_BIT;
            end

            bba_pkg::ST_SCAN_BIT:
            begin
                run_next = run_step;
                if (run_step == needed_reg)
                begin
                    first_next = start_blk;
                    last_next  = k_reg;
                    k_next     = start_blk;
                    len_next   = needed_reg;
                    set_next   = 1'b1;
                    used_next  = used_reg + needed_reg;
                    ok_next    = 1'b1;
                    addr_next  = bba_pkg::ADDR_W'({start_blk, {OFS{1'b0}}})
                                 + bba_pkg::ADDR_W'(bba_pkg::HEADER_BYTES);
                    state_next = bba_pkg::ST_MARK_RD;
                end
                else if (CNT_W'(k_reg) == total_reg - CNT_W'(1))
                begin
                    state_next = bba_pkg::ST_DONE;
                end
                else
                begin
                    k_next = k_reg + BLK_W'(1);
                    if (k_reg[ROW_W-1:0] == {ROW_W{1'b1}})
                    begin
                        state_next = bba_pkg::ST_SCAN_RD;
                    end
                end
            end

            // Marking sweep: read a row, update it bit by bit, write it back
            bba_pkg::ST_MARK_RD:
            begin
                occ_rd_en   = 1'b1;
                rvld_q_next = row_vld_reg[k_reg[BLK_W-1:ROW_W]];
                state_next  = bba_pkg::ST_MARK_LD;
            end

            bba_pkg::ST_MARK_LD:
            begin
                row_buf_next = occ_word;
                wrow_next    = k_reg[BLK_W-1:ROW_W];
                state_next   = bba_pkg::ST_MARK_BIT;
            end

            bba_pkg::ST_MARK_BIT:
            begin
                row_buf_next[k_reg[ROW_W-1:0]] = set_reg;
                rl_wr_en   = 1'b1;
                rl_wr_data = (set_reg && k_reg == first_reg) ? len_reg : '0;
                done_next  = (k_reg == last_reg);
                if (k_reg == last_reg)
                begin
                    state_next = bba_pkg::ST_MARK_WR;
                end
                else
                begin
                    k_next = k_reg + BLK_W'(1);
                    if (k_reg[ROW_W-1:0] == {ROW_W{1'b1}})
                    begin
                        state_next = bba_pkg::ST_MARK_WR;
                    end
                end
            end

            bba_pkg::ST_MARK_WR:
            begin
                occ_wr_en              = 1'b1;
                row_vld_next[wrow_reg] = 1'b1;
                state_next = done_reg ? bba_pkg::ST_DONE : bba_pkg::ST_MARK_RD;
            end

            // Free: fetch the start row and its recorded run length
            bba_pkg::ST_FREE_RD:
            begin
                occ_rd_en   = 1'b1;
                occ_rd_addr = first_reg[BLK_W-1:ROW_W];
                rvld_q_next = row_vld_reg[first_reg[BLK_W-1:ROW_W]];
                rl_rd_en    = 1'b1;
                k_next      = first_reg;
                state_next  = bba_pkg::ST_FREE_CHK;
            end

            bba_pkg::ST_FREE_CHK:
            begin
                if (!bit_val || rl_rd_data == '0
                    || end_sum > (CNT_W+1)'(total_reg))
                begin
                    state_next = bba_pkg::ST_DONE;
                end
                else
                begin
                    len_next   = rl_rd_data;
                    last_next  = BLK_W'(end_sum - (CNT_W+1)'(1));
                    set_next   = 1'b0;
                    used_next  = used_reg - rl_rd_data;
                    ok_next    = 1'b1;
                    state_next = bba_pkg::ST_MARK_LD;
                end
            end

            // Check: read the occupancy bit of the header block
            bba_pkg::ST_CHK_RD:
            begin
                occ_rd_en   = 1'b1;
                rvld_q_next = row_vld_reg[k_reg[BLK_W-1:ROW_W]];
                state_next  = bba_pkg::ST_CHK_BIT;
            end

            bba_pkg::ST_CHK_BIT:
            begin
                alloc_next = bit_val;
                state_next = bba_pkg::ST_DONE;
            end

            // Hand the result word to the output register
            bba_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = bba_pkg::OUT_DATA_W'({total_reg - used_reg, used_reg,
                                                           alloc_reg, addr_reg, ok_reg});
                    state_next    = bba_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bba_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bba_pkg::ST_IDLE;
            total_reg    <= CNT_W'(bba_pkg::NUM_BLOCKS);
            used_reg     <= '0;
            row_vld_reg  <= '0;
            rvld_q_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            used_reg     <= used_next;
            row_vld_reg  <= row_vld_next;
            rvld_q_reg   <= rvld_q_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        size_reg    <= size_next;
        off_reg     <= off_next;
        needed_reg  <= needed_next;
        run_reg     <= run_next;
        len_reg     <= len_next;
        k_reg       <= k_next;
        first_reg   <= first_next;
        last_reg    <= last_next;
        wrow_reg    <= wrow_next;
        row_buf_reg <= row_buf_next;
        set_reg     <= set_next;
        done_reg    <= done_next;
        ok_reg      <= ok_next;
        addr_reg    <= addr_next;
        alloc_reg   <= alloc_next;
        m_tdata_reg <= m_tdata_next;
    end

    // The used count can never pass the managed block count
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= total_reg)
        else $error("used block count exceeds total blocks");

    // A configuration write leaves the map empty
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> used_reg == '0 && row_vld_reg == '0)
        else $error("configuration write did not clear the map");

    // The marking sweep stays inside the run being updated
    a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bba_pkg::ST_MARK_BIT |-> k_reg >= first_reg && k_reg <= last_reg)
        else $error("marking sweep left its run");

    // The scan stops as soon as the run length reaches the request
    a_scan_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bba_pkg::ST_SCAN_BIT |-> run_reg < needed_reg)
        else $error("scan continued past a complete run");

endmodule

@@ sv/bba_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read; read data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ test/bitmap_block_allocator_tb.sv @@
// Self-checking testbench for the first-fit bitmap block allocator with random stream stalls.
module bitmap_block_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Request code the block must treat as a no-op
    localparam logic [bba_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [bba_pkg::REQ_W-1:0]  kind;
        logic [bba_pkg::SIZE_W-1:0] size;
        logic [bba_pkg::OFFS_W-1:0] offset;
    } req_t;

    typedef struct packed {
        logic                       ok;
        logic [bba_pkg::ADDR_W-1:0] addr;
        logic                       alloc;
        logic [bba_pkg::CNT_W-1:0]  used_blk;
        logic [bba_pkg::CNT_W-1:0]  free_blk;
    } reply_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [bba_pkg::CNT_W-1:0]      cfg_data = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [bba_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic [bba_pkg::REQ_W-1:0]      s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [bba_pkg::OUT_DATA_W-1:0] m_tdata;

    // Shadow allocator state
    bit  blk_busy [bba_pkg::NUM_BLOCKS];
    int  run_len [bba_pkg::NUM_BLOCKS];
    int  used_cnt;
    int  area_blocks;

    req_t   pending_reqs [$];
    reply_t expected_replies [$];
    int     mismatch_cnt = 0;
    int     replies_seen = 0;
    logic   in_taken = 1'b0;
    logic   hold_rx = 1'b0;
    int     gap_left = 0;
    int     burst_left = 0;
    int     rx_wait = 0;

    bitmap_block_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // A block count write clamps the value and empties the whole area.
    function automatic void set_area(input logic [bba_pkg::CNT_W-1:0] value);
        int n;
        n = int'(value);
        if (n == 0)
            n = 1;
        if (n > bba_pkg::NUM_BLOCKS)
            n = bba_pkg::NUM_BLOCKS;
        area_blocks = n;
        for (int k = 0; k < bba_pkg::NUM_BLOCKS; k++)
        begin
            blk_busy[k] = 1'b0;
            run_len[k] = 0;
        end
        used_cnt = 0;
    endfunction

    // Applies one request to the shadow state and returns the word the block should send.
    function automatic reply_t predict_reply(input req_t rq);
        reply_t r;
        int     cap, sz, off, need, run, start, hdr, len;
        r = '0;
        cap = area_blocks * bba_pkg::BLOCK_BYTES;
        sz = int'(rq.size);
        off = int'(rq.offset);
        case (rq.kind)
            bba_pkg::REQ_ALLOC:
            begin
                if (sz != 0 && sz <= cap)
                begin
                    need = (sz + bba_pkg::HEADER_BYTES + bba_pkg::BLOCK_BYTES - 1)
                           / bba_pkg::BLOCK_BYTES;
                    start = -1;
                    if (need <= area_blocks)
                    begin
                        // Lowest free run of the needed length wins.
                        run = 0;
                        for (int k = 0; k < area_blocks && start < 0; k++)
                        begin
                            if (blk_busy[k])
                                run = 0;
                            else
                                run++;
                            if (run == need)
                                start = k + 1 - need;
                        end
                    end
                    if (start >= 0)
                    begin
                        for (int k = start; k < start + need; k++)
                            blk_busy[k] = 1'b1;
                        run_len[start] = need;
                        used_cnt += need;
                        r.ok = 1'b1;
                        r.addr = bba_pkg::ADDR_W'(start * bba_pkg::BLOCK_BYTES
                                                  + bba_pkg::HEADER_BYTES);
                    end
                end
            end
            bba_pkg::REQ_FREE:
            begin
                if (off >= bba_pkg::HEADER_BYTES)
                begin
                    hdr = off - bba_pkg::HEADER_BYTES;
                    if (hdr < cap)
                    begin
                        start = hdr / bba_pkg::BLOCK_BYTES;
                        len = run_len[start];
                        // Only a recorded run start that is still occupied gets released.
                        if (start + len <= area_blocks && blk_busy[start] && len != 0)
                        begin
                            for (int k = start; k < start + len; k++)
                                blk_busy[k] = 1'b0;
                            run_len[start] = 0;
                            used_cnt -= len;
                            r.ok = 1'b1;
                        end
                    end
                end
            end
            bba_pkg::REQ_CHECK:
            begin
                if (off < cap && off >= bba_pkg::HEADER_BYTES)
                    r.alloc = blk_busy[(off - bba_pkg::HEADER_BYTES) / bba_pkg::BLOCK_BYTES];
            end
            default:
            begin
            end
        endcase
        r.used_blk = bba_pkg::CNT_W'(used_cnt);
        r.free_blk = bba_pkg::CNT_W'(area_blocks - used_cnt);
        return r;
    endfunction

    // Offset for free and check: mostly a live allocation, sometimes anything.
    function automatic int pick_offset();
        int starts [$];
        int r, cap, st;
        cap = area_blocks * bba_pkg::BLOCK_BYTES;
        for (int k = 0; k < area_blocks; k++)
            if (run_len[k] != 0)
                starts.push_back(k);
        r = int'($urandom_range(0, 99));
        if (r < 70 && starts.size() > 0)
        begin
            st = starts[$urandom_range(0, starts.size() - 1)];
            return st * bba_pkg::BLOCK_BYTES + bba_pkg::HEADER_BYTES
                   + ((r < 40) ? 0 : int'($urandom_range(0, 63)));
        end
        if (r < 80)
            return int'($urandom_range(0, cap + bba_pkg::BLOCK_BYTES));
        if (r < 92)
            return int'($urandom_range(0, area_blocks - 1)) * bba_pkg::BLOCK_BYTES
                   + bba_pkg::HEADER_BYTES;
        return int'($urandom_range(0, 131071));
    endfunction

    task automatic push_req(input logic [bba_pkg::REQ_W-1:0] kind, input int size,
                            input int offset);
        req_t rq;
        rq.kind = kind;
        rq.size = bba_pkg::SIZE_W'(size);
        rq.offset = bba_pkg::OFFS_W'(offset);
        pending_reqs.push_back(rq);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    // Block until every queued request has been answered; returns at a falling edge.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_replies.size() != 0);
        @(negedge clk);
    endtask

    task automatic write_area(input logic [bba_pkg::CNT_W-1:0] value);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Request driver: offers queued words with random gaps and gap-free bursts.
    always @(negedge clk)
    begin : feed
        req_t rq;
        int   r;
        int   g;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                rq = pending_reqs.pop_front();
                s_tuser <= rq.kind;
                s_tdata <= {{(bba_pkg::IN_DATA_W - bba_pkg::SIZE_W - bba_pkg::OFFS_W){1'b0}},
                            rq.offset, rq.size};
                s_tvalid <= 1'b1;
                g = 0;
                r = int'($urandom_range(0, 99));
                if (burst_left > 0)
                    burst_left--;
                else if (r < 50)
                    g = 0;
                else if (r < 82)
                    g = int'($urandom_range(1, 3));
                else if (r < 94)
                    burst_left = int'($urandom_range(8, 30));
                else
                    g = int'($urandom_range(15, 80));
                gap_left = g;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result receiver: random stalls, plus the long hold-off when requested.
    always @(negedge clk)
    begin : drain
        int r;
        r = int'($urandom_range(0, 99));
        if (rx_wait > 0)
            rx_wait--;
        else if (r >= 75)
            rx_wait = (r < 92) ? int'($urandom_range(1, 3)) :
                      (r < 98) ? int'($urandom_range(4, 12)) : int'($urandom_range(30, 120));
        m_tready <= rst_n && !hold_rx && rx_wait == 0;
    end

    // Long receiver hold-offs so the block backs up and stalls its input.
    initial
    begin : long_hold
        wait (replies_seen >= 10);
        @(negedge clk);
        hold_rx <= 1'b1;
        repeat (300) @(negedge clk);
        hold_rx <= 1'b0;
        wait (replies_seen >= 320);
        @(negedge clk);
        hold_rx <= 1'b1;
        repeat (400) @(negedge clk);
        hold_rx <= 1'b0;
    end

    // Monitor: tracks config writes, predicts accepted requests, checks result words.
    always @(posedge clk)
    begin : monitor
        req_t   rq;
        reply_t want;
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            if (cfg_valid && cfg_ready)
                set_area(cfg_data);
            if (m_tvalid && m_tready)
            begin
                replies_seen++;
                if (expected_replies.size() == 0)
                begin
                    $display("%0t ns: result word mismatch, expected none, actual 0x%h",
                             $time, m_tdata);
                    mismatch_cnt++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    check_field("ok", int'(want.ok), int'(m_tdata[0]));
                    check_field("result_addr", int'(want.addr), int'(m_tdata[16:1]));
                    check_field("is_allocated", int'(want.alloc), int'(m_tdata[17]));
                    check_field("busy_count", int'(want.used_blk), int'(m_tdata[28:18]));
                    check_field("free_blocks", int'(want.free_blk), int'(m_tdata[39:29]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                rq.kind = s_tuser;
                rq.size = s_tdata[bba_pkg::SIZE_W-1:0];
                rq.offset = s_tdata[bba_pkg::SIZE_W+bba_pkg::OFFS_W-1:bba_pkg::SIZE_W];
                expected_replies.push_back(predict_reply(rq));
            end
            in_taken <= s_tvalid && s_tready;
        end
    end

    // Stimulus sequence
    initial
    begin : stimulus
        req_t                      rq;
        logic [bba_pkg::CNT_W-1:0] area_val;
        int                        left, n, r, r2, s, cap;
        set_area(bba_pkg::CNT_W'(bba_pkg::NUM_BLOCKS));
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: boundaries of alloc, free and check on the full area.
        push_req(bba_pkg::REQ_CHECK, int'($urandom_range(0, 131071)), 8);
        push_req(bba_pkg::REQ_ALLOC, 0, int'($urandom_range(0, 131071)));
        push_req(bba_pkg::REQ_ALLOC, 1, 0);
        push_req(bba_pkg::REQ_ALLOC, 56, 0);
        push_req(bba_pkg::REQ_ALLOC, 57, 131071);
        push_req(bba_pkg::REQ_CHECK, 131071, 8);
        push_req(bba_pkg::REQ_CHECK, 0, 7);
        push_req(bba_pkg::REQ_CHECK, 0, 131071);
        push_req(bba_pkg::REQ_FREE, 0, 72);
        push_req(bba_pkg::REQ_FREE, 131071, 72);
        // Header of a block in the middle of a run has no recorded length.
        push_req(bba_pkg::REQ_FREE, 0, 200);
        push_req(bba_pkg::REQ_FREE, 0, 0);
        push_req(bba_pkg::REQ_FREE, 0, 131071);
        // Unaligned offset still lands in the first block.
        push_req(bba_pkg::REQ_FREE, 0, 9);
        push_req(bba_pkg::REQ_ALLOC, 65536, 0);
        push_req(bba_pkg::REQ_ALLOC, 131071, 0);
        push_req(bba_pkg::REQ_ALLOC, 65528, 0);
        push_req(bba_pkg::REQ_FREE, 0, 136);
        push_req(bba_pkg::REQ_ALLOC, 65528, 0);
        push_req(bba_pkg::REQ_ALLOC, 1, 0);
        push_req(bba_pkg::REQ_CHECK, 0, 65535);
        push_req(bba_pkg::REQ_CHECK, 0, 65536);
        push_req(bba_pkg::REQ_FREE, 0, 8);
        push_req(REQ_UNKNOWN, 131071, 131071);

        // Random phases, each starting with a block count write.
        for (int p = 0; p < 10; p++)
        begin
            wait_idle();
            case (p)
                0: area_val = 11'd0;
                1: area_val = 11'd1;
                2: area_val = 11'd2047;
                3: area_val = 11'd8;
                4: area_val = 11'd33;
                5: area_val = 11'd1024;
                6: area_val = bba_pkg::CNT_W'($urandom_range(2, 64));
                7: area_val = bba_pkg::CNT_W'($urandom_range(65, 600));
                8: area_val = 11'd100;
                default: area_val = 11'd1024;
            endcase
            write_area(area_val);
            left = 56;
            while (left > 0)
            begin
                n = int'($urandom_range(6, 16));
                if (n > left)
                    n = left;
                for (int i = 0; i < n; i++)
                begin
                    cap = area_blocks * bba_pkg::BLOCK_BYTES;
                    rq.size = bba_pkg::SIZE_W'($urandom_range(0, 131071));
                    rq.offset = bba_pkg::OFFS_W'($urandom_range(0, 131071));
                    r = int'($urandom_range(0, 99));
                    if (r < 42)
                    begin
                        rq.kind = bba_pkg::REQ_ALLOC;
                        r2 = int'($urandom_range(0, 99));
                        if (r2 < 60)
                            s = int'($urandom_range(1, cap / 4));
                        else if (r2 < 75)
                            s = int'($urandom_range(1, 120));
                        else if (r2 < 83)
                            s = cap - int'($urandom_range(0, 72));
                        else if (r2 < 87)
                            s = 0;
                        else if (r2 < 92)
                            s = cap + int'($urandom_range(1, 64));
                        else if (r2 < 97)
                            s = int'($urandom_range(0, 131071));
                        else
                            s = 131071;
                        if (s < 0)
                            s = 0;
                        rq.size = bba_pkg::SIZE_W'(s);
                    end
                    else if (r < 72)
                    begin
                        rq.kind = bba_pkg::REQ_FREE;
                        rq.offset = bba_pkg::OFFS_W'(pick_offset());
                    end
                    else if (r < 95)
                    begin
                        rq.kind = bba_pkg::REQ_CHECK;
                        rq.offset = bba_pkg::OFFS_W'(pick_offset());
                    end
                    else
                        rq.kind = REQ_UNKNOWN;
                    pending_reqs.push_back(rq);
                end
                left -= n;
                wait_idle();
            end
        end

        wait_idle();
        repeat (2500) @(negedge clk);
        if (mismatch_cnt == 0 && expected_replies.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        #60_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/bba_pkg.sv
sv/bba_ram.sv
sv/bitmap_block_allocator.sv
test/bitmap_block_allocator_tb.sv
